// ===== hw/rtl/height_relief_pixel_shader_unit_assert.svh =====
// Assertion macros for the relief shader unit checks.
`ifndef HEIGHT_RELIEF_PIXEL_SHADER_UNIT_ASSERT_SVH
`define HEIGHT_RELIEF_PIXEL_SHADER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, switched off while rst is high.
`define HRPSU_ASSERT_NOW(label, cond, conseq) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
    else $error("relief shader: same-cycle check failed");

// Next-cycle implication, sampled on clk, switched off while rst is high.
`define HRPSU_ASSERT_NEXT(label, cond, conseq) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error("relief shader: next-cycle check failed");

`endif

// ===== hw/rtl/hrps_pkg.sv =====
// Shared types, constants and shade table for the relief shader unit.
`timescale 1ns / 1ps
`default_nettype none

package hrps_pkg;

  localparam int COLOR_BITS   = 8;
  localparam int SURFACE_BITS = 10;
  localparam int COLUMN_BITS  = 9;
  localparam int FRAC_BITS    = 16;
  localparam int FACTOR_BITS  = 17;
  localparam int PRODUCT_BITS = COLOR_BITS + FACTOR_BITS;
  localparam int SCALED_BITS  = PRODUCT_BITS - FRAC_BITS;
  localparam int INDEX_BITS   = 3;

  localparam logic [COLOR_BITS-1:0] MIST_RED    = 8'd8;
  localparam logic [COLOR_BITS-1:0] MIST_GREEN  = 8'd8;
  localparam logic [COLOR_BITS-1:0] MIST_BLUE   = 8'd12;
  localparam logic [COLOR_BITS-1:0] CHANNEL_MAX = 8'd255;

  // Height difference is clamped to plus or minus this many levels.
  localparam int DIFF_LIMIT = 3;

  localparam logic [INDEX_BITS-1:0]  IDX_LOWEST  = 3'd0;
  localparam logic [INDEX_BITS-1:0]  IDX_HIGHEST = 3'd6;
  localparam logic [FACTOR_BITS-1:0] FACTOR_UNITY = 17'd65536;

  typedef struct packed {
    logic [COLOR_BITS-1:0]   red_in;
    logic [COLOR_BITS-1:0]   green_in;
    logic [COLOR_BITS-1:0]   blue_in;
    logic [SURFACE_BITS-1:0] surface_height;
    logic                    explored;
    logic [COLUMN_BITS-1:0]  column;
    logic                    top_row;
  } texel_t;

  typedef struct packed {
    logic [COLOR_BITS-1:0] red_out;
    logic [COLOR_BITS-1:0] green_out;
    logic [COLOR_BITS-1:0] blue_out;
  } pixel_t;

  typedef struct packed {
    logic [COLOR_BITS-1:0] red;
    logic [COLOR_BITS-1:0] green;
    logic [COLOR_BITS-1:0] blue;
  } rgb_t;

  // Colour plus its chosen Q1.16 shade factor.
  typedef struct packed {
    logic                   mist;
    rgb_t                   colour;
    logic [FACTOR_BITS-1:0] factor;
  } shade_t;

  // Scaled channels after the fraction bits are dropped, before saturation.
  typedef struct packed {
    logic                   mist;
    logic [SCALED_BITS-1:0] red;
    logic [SCALED_BITS-1:0] green;
    logic [SCALED_BITS-1:0] blue;
  } product_t;

  // round((1 + 0.09 * d) * 65536) for d = -3 .. 3, indexed by d + 3.
  function automatic logic [FACTOR_BITS-1:0] shade_factor(input logic [INDEX_BITS-1:0] idx);
    logic [FACTOR_BITS-1:0] f;
    case (idx)
      3'd0:    f = 17'd47841;
      3'd1:    f = 17'd53740;
      3'd2:    f = 17'd59638;
      3'd3:    f = 17'd65536;
      3'd4:    f = 17'd71434;
      3'd5:    f = 17'd77332;
      3'd6:    f = 17'd83231;
      default: f = FACTOR_UNITY;
    endcase
    return f;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/hrps_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module hrps_ram #(
  parameter int WIDTH = 11,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read returns the old word when the same address is written in that cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/hrps_factor.sv =====
// Relief stage: height difference, clamp and shade factor selection.
`timescale 1ns / 1ps
`default_nettype none

module hrps_factor #(
  parameter int HEIGHT_BITS = 10
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 load,
  input  wire logic                 in_valid,
  input  wire hrps_pkg::rgb_t       colour,
  input  wire logic                 explored,
  input  wire logic                 has_north,
  input  wire logic [HEIGHT_BITS-1:0] height,
  input  wire logic [HEIGHT_BITS:0] north,
  output hrps_pkg::shade_t          shade,
  output logic                      valid
);

  localparam int DW = HEIGHT_BITS + 1;
  localparam logic signed [DW-1:0] LIMIT_POS = DW'(hrps_pkg::DIFF_LIMIT);
  localparam logic signed [DW-1:0] LIMIT_NEG = -LIMIT_POS;

  logic signed [DW-1:0]               diff;
  logic signed [DW-1:0]               diff_off;
  logic [hrps_pkg::INDEX_BITS-1:0]    idx;
  logic                               relief;
  hrps_pkg::shade_t                   shade_next;

  always_comb begin
    diff     = $signed({1'b0, height}) - $signed({1'b0, north[HEIGHT_BITS:1]});
    diff_off = diff + LIMIT_POS;
    if (diff < LIMIT_NEG) begin
      idx = hrps_pkg::IDX_LOWEST;
    end else if (diff > LIMIT_POS) begin
      idx = hrps_pkg::IDX_HIGHEST;
    end else begin
      idx = hrps_pkg::INDEX_BITS'(diff_off);
    end
    // Shade only against an explored northern neighbour.
    relief            = has_north && north[0];
    shade_next.mist   = !explored;
    shade_next.colour = colour;
    shade_next.factor = relief ? hrps_pkg::shade_factor(idx) : hrps_pkg::FACTOR_UNITY;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      shade <= shade_next;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/hrps_scale.sv =====
// Scale stages: channel multiply, then saturation and mist select.
`timescale 1ns / 1ps
`default_nettype none

module hrps_scale (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             load_mul,
  input  wire logic             load_out,
  input  wire logic             in_valid,
  input  wire hrps_pkg::shade_t shade,
  output logic                  mul_valid,
  output hrps_pkg::pixel_t      pixel,
  output logic                  pixel_valid
);

  logic [hrps_pkg::PRODUCT_BITS-1:0] prod_r;
  logic [hrps_pkg::PRODUCT_BITS-1:0] prod_g;
  logic [hrps_pkg::PRODUCT_BITS-1:0] prod_b;
  hrps_pkg::product_t                prod;
  hrps_pkg::product_t                prod_next;
  hrps_pkg::pixel_t                  pixel_next;

  always_comb begin
    prod_r = hrps_pkg::PRODUCT_BITS'(shade.colour.red)
           * hrps_pkg::PRODUCT_BITS'(shade.factor);
    prod_g = hrps_pkg::PRODUCT_BITS'(shade.colour.green)
           * hrps_pkg::PRODUCT_BITS'(shade.factor);
    prod_b = hrps_pkg::PRODUCT_BITS'(shade.colour.blue)
           * hrps_pkg::PRODUCT_BITS'(shade.factor);
    prod_next.mist  = shade.mist;
    prod_next.red   = prod_r[hrps_pkg::PRODUCT_BITS-1:hrps_pkg::FRAC_BITS];
    prod_next.green = prod_g[hrps_pkg::PRODUCT_BITS-1:hrps_pkg::FRAC_BITS];
    prod_next.blue  = prod_b[hrps_pkg::PRODUCT_BITS-1:hrps_pkg::FRAC_BITS];
  end

  // Mist if unexplored, else clamp above one byte to full scale.
  always_comb begin
    if (prod.mist) begin
      pixel_next.red_out   = hrps_pkg::MIST_RED;
      pixel_next.green_out = hrps_pkg::MIST_GREEN;
      pixel_next.blue_out  = hrps_pkg::MIST_BLUE;
    end else begin
      pixel_next.red_out   = prod.red[hrps_pkg::COLOR_BITS] ? hrps_pkg::CHANNEL_MAX
                                                            : prod.red[hrps_pkg::COLOR_BITS-1:0];
      pixel_next.green_out = prod.green[hrps_pkg::COLOR_BITS] ? hrps_pkg::CHANNEL_MAX
                                                              : prod.green[hrps_pkg::COLOR_BITS-1:0];
      pixel_next.blue_out  = prod.blue[hrps_pkg::COLOR_BITS] ? hrps_pkg::CHANNEL_MAX
                                                             : prod.blue[hrps_pkg::COLOR_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_valid   <= 1'b0;
      pixel_valid <= 1'b0;
    end else begin
      if (load_mul) begin
        mul_valid <= in_valid;
      end
      if (load_out) begin
        pixel_valid <= mul_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_mul) begin
      prod <= prod_next;
    end
    if (load_out) begin
      pixel <= pixel_next;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/height_relief_pixel_shader_unit.sv =====
// Top level of the heightmap relief shader: line store and pipeline control.
//
// Usage: texels enter on the texel channel (texel_valid / texel_stall) in raster
// order, one packed texel_t per transfer; shaded colours leave on the pixel
// channel (pixel_valid / pixel_stall) as one pixel_t per texel, in order.
// The unit takes one texel every cycle while texel_stall is low. The transfer
// edge loads the read stage while the line store is read, then shade factor,
// channel multiply, and saturation into the output register follow.
// The line store has one read port and one write port, both used at the texel
// transfer: a column is read and rewritten in the same cycle, so the next texel
// in that column sees the new entry with no forwarding.
// Reset clears every stage valid bit; the line store is not cleared, so the
// first row must come in with top_row set before any lower row is read.
// When the receiver stalls, the output register holds its pixel and the stages
// behind it keep filling until the pipe is full; only then is texel_stall
// raised. Nothing is dropped or repeated.
`timescale 1ns / 1ps
`default_nettype none

module height_relief_pixel_shader_unit #(
  parameter int MAP_WIDTH   = 512,
  parameter int HEIGHT_BITS = 10
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              texel_valid,
  output logic                   texel_stall,
  input  wire hrps_pkg::texel_t  texel,
  output logic                   pixel_valid,
  input  wire logic              pixel_stall,
  output hrps_pkg::pixel_t       pixel
);

  localparam int AW = $clog2(MAP_WIDTH);
  localparam int CW = AW + hrps_pkg::COLUMN_BITS;
  localparam int HW = HEIGHT_BITS + hrps_pkg::SURFACE_BITS;

  // Stage advance enables, from the output back to the input.
  logic adv_out;
  logic adv_mul;
  logic adv_fac;
  logic adv_rd;
  logic accept;

  logic                   mul_valid;
  logic                   fac_valid;
  hrps_pkg::shade_t       shade;

  // Line store addressing and write word.
  logic [CW-1:0]          col_wide;
  logic [AW-1:0]          addr;
  logic                   in_map;
  logic [HW-1:0]          height_wide;
  logic [HEIGHT_BITS-1:0] height_in;
  logic [HEIGHT_BITS:0]   north;

  // Read stage registers: the texel waits here while its north entry is read.
  logic                   rd_valid;
  hrps_pkg::rgb_t         rd_colour;
  logic                   rd_explored;
  logic                   rd_has_north;
  logic [HEIGHT_BITS-1:0] rd_height;

  // Each stage moves when the one ahead is empty or moving.
  assign adv_out     = !pixel_valid || !pixel_stall;
  assign adv_mul     = !mul_valid || adv_out;
  assign adv_fac     = !fac_valid || adv_mul;
  assign adv_rd      = !rd_valid || adv_fac;
  assign texel_stall = !adv_rd;
  assign accept      = texel_valid && adv_rd;

  always_comb begin
    col_wide    = CW'(texel.column);
    addr        = col_wide[AW-1:0];
    in_map      = 32'(texel.column) < MAP_WIDTH;
    height_wide = HW'(texel.surface_height);
    height_in   = height_wide[HEIGHT_BITS-1:0];
  end

  // Read the old entry and write the new one at the same transfer; columns
  // beyond the map use no neighbour and never write the store.
  hrps_ram #(
    .WIDTH (HEIGHT_BITS + 1),
    .DEPTH (MAP_WIDTH)
  ) u_line_store (
    .clk   (clk),
    .we    (accept && in_map),
    .waddr (addr),
    .wdata ({height_in, texel.explored}),
    .re    (accept),
    .raddr (addr),
    .rdata (north)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else if (adv_rd) begin
      rd_valid <= texel_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_rd) begin
      rd_colour.red   <= texel.red_in;
      rd_colour.green <= texel.green_in;
      rd_colour.blue  <= texel.blue_in;
      rd_explored     <= texel.explored;
      rd_has_north    <= in_map && !texel.top_row;
      rd_height       <= height_in;
    end
  end

  hrps_factor #(
    .HEIGHT_BITS (HEIGHT_BITS)
  ) u_factor (
    .clk       (clk),
    .rst       (rst),
    .load      (adv_fac),
    .in_valid  (rd_valid),
    .colour    (rd_colour),
    .explored  (rd_explored),
    .has_north (rd_has_north),
    .height    (rd_height),
    .north     (north),
    .shade     (shade),
    .valid     (fac_valid)
  );

  hrps_scale u_scale (
    .clk         (clk),
    .rst         (rst),
    .load_mul    (adv_mul),
    .load_out    (adv_out),
    .in_valid    (fac_valid),
    .shade       (shade),
    .mul_valid   (mul_valid),
    .pixel       (pixel),
    .pixel_valid (pixel_valid)
  );

  `include "height_relief_pixel_shader_unit_assert.svh"

  // Back-pressure on the input only ever comes from a full pipe behind a stalled output.
  `HRPSU_ASSERT_NOW(a_stall_only_when_full, texel_stall, pixel_valid && pixel_stall && mul_valid && fac_valid && rd_valid)
  // An accepted texel always lands in the read stage.
  `HRPSU_ASSERT_NEXT(a_accept_lands, texel_valid && !texel_stall, rd_valid)
  // A product facing a free output register moves into it.
  `HRPSU_ASSERT_NEXT(a_product_drains, mul_valid && !(pixel_valid && pixel_stall), pixel_valid)

endmodule

`default_nettype wire
